[rtl/core/awt_pkg.sv]
package awt_pkg;

    localparam int CHANNELS    = 8;
    localparam int WINDOW_BITS = 32;
    localparam int CH_W        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CHAN_IN_W   = 8;
    localparam int CMD_W       = 3;
    localparam int SEQ_W       = 32;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [SEQ_W-1:0] WIN_MASK =
        SEQ_W'((64'd1 << WINDOW_BITS) - 64'd1);
    localparam logic [SEQ_W-1:0] WIN_SIZE = SEQ_W'(WINDOW_BITS);

    // input command codes
    localparam logic [CMD_W-1:0] CMD_SEND  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_RECV  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_ACK   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_QUERY = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd4;

    // decoded operation codes
    typedef logic [2:0] op_t;
    localparam op_t OP_SEND  = 3'd0;
    localparam op_t OP_RECV  = 3'd1;
    localparam op_t OP_ACK   = 3'd2;
    localparam op_t OP_QUERY = 3'd3;
    localparam op_t OP_CLEAR = 3'd4;
    localparam op_t OP_NOP   = 3'd5;

    typedef struct packed {
        op_t             op;
        logic            ch_ok;
        logic [CH_W-1:0] ch;
        logic [SEQ_W-1:0] seq;
        logic [SEQ_W-1:0] ack;
        logic [SEQ_W-1:0] bits;
    } work_t;

    typedef struct packed {
        logic [SEQ_W-1:0] ns;
        logic [SEQ_W-1:0] hr;
        logic [SEQ_W-1:0] rw;
        logic [SEQ_W-1:0] pa;
        logic [SEQ_W-1:0] pw;
    } chan_t;

    localparam chan_t CHAN_RESET = '{
        ns: SEQ_W'(1), hr: '0, rw: '0, pa: '0, pw: '0
    };

endpackage

[rtl/core/awt_if.sv]
interface awt_req_if
    import awt_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CMD_W-1:0]     command;
    logic [CHAN_IN_W-1:0] channel;
    logic [SEQ_W-1:0]     seq_value;
    logic [SEQ_W-1:0]     ack_value;
    logic [SEQ_W-1:0]     ack_bits_in;

    modport source (output valid, command, channel, seq_value, ack_value, ack_bits_in,
                    input ready);
    modport sink   (input valid, command, channel, seq_value, ack_value, ack_bits_in,
                    output ready);
endinterface

interface awt_rsp_if
    import awt_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             flag;
    logic [SEQ_W-1:0] send_seq;
    logic [SEQ_W-1:0] local_ack;
    logic [SEQ_W-1:0] local_ack_bits;
    logic             channel_ok;

    modport source (output valid, flag, send_seq, local_ack, local_ack_bits, channel_ok,
                    input ready);
    modport sink   (input valid, flag, send_seq, local_ack, local_ack_bits, channel_ok,
                    output ready);
endinterface

[rtl/core/awt_front.sv]
module awt_front
    import awt_pkg::*;
(
    awt_req_if.sink req,
    output logic    push_valid,
    input  logic    push_ready,
    output work_t   push_data
);

    always_comb
    begin
        push_data.ch_ok = ({1'b0, req.channel} < (CHAN_IN_W + 1)'(CHANNELS));
        push_data.ch    = CH_W'(req.channel);
        push_data.seq   = req.seq_value;
        push_data.ack   = req.ack_value;
        push_data.bits  = req.ack_bits_in;
        unique case (req.command)
            CMD_SEND:  push_data.op = OP_SEND;
            CMD_RECV:  push_data.op = OP_RECV;
            CMD_ACK:   push_data.op = OP_ACK;
            CMD_QUERY: push_data.op = OP_QUERY;
            CMD_CLEAR: push_data.op = OP_CLEAR;
            default:   push_data.op = OP_NOP;
        endcase
    end

    assign push_valid = req.valid;
    assign req.ready  = push_ready;

endmodule

[rtl/core/awt_fifo.sv]
module awt_fifo
    import awt_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push_valid,
    output logic  push_ready,
    input  work_t push_data,
    output logic  pop_valid,
    input  logic  pop_ready,
    output work_t pop_data
);

    work_t               mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   cnt_reg, cnt_next;
    logic                push, pop;

    assign push_ready = (cnt_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[rtl/core/awt_back.sv]
module awt_back
    import awt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      pop_valid,
    output logic      pop_ready,
    input  work_t     pop_data,
    awt_rsp_if.source rsp
);

    chan_t            tbl_reg [CHANNELS];
    chan_t            cur, nxt;
    logic             flag;
    logic [SEQ_W-1:0] sent;
    logic [SEQ_W-1:0] d_r, d_q;
    logic [4:0]       d_r_m1, d_q_m1;
    logic [63:0]      w64;
    logic [SEQ_W-1:0] bit_r;
    logic             pop;

    logic             out_valid_reg;
    logic             flag_reg;
    logic [SEQ_W-1:0] send_seq_reg;
    logic [SEQ_W-1:0] local_ack_reg;
    logic [SEQ_W-1:0] local_bits_reg;
    logic             ch_ok_reg;

    assign pop_ready = !out_valid_reg || rsp.ready;
    assign pop       = pop_valid && pop_ready;

    always_comb
    begin
        cur    = tbl_reg[pop_data.ch];
        nxt    = cur;
        flag   = 1'b0;
        sent   = '0;
        d_r    = (pop_data.seq > cur.hr) ? pop_data.seq - cur.hr : cur.hr - pop_data.seq;
        d_q    = cur.pa - pop_data.seq;
        d_r_m1 = 5'(d_r - 1'b1);
        d_q_m1 = 5'(d_q - 1'b1);
        w64    = ({32'd0, cur.rw} << d_r[5:0]) | (64'd1 << d_r_m1);
        bit_r  = SEQ_W'(1) << d_r_m1;
        if (pop_data.ch_ok)
        begin
            unique case (pop_data.op)
                OP_SEND:
                begin
                    sent   = cur.ns;
                    nxt.ns = cur.ns + 1'b1;
                end
                OP_RECV:
                begin
                    priority if (pop_data.seq == '0)
                    begin
                        flag = 1'b0;
                    end
                    else if (cur.hr == '0)
                    begin
                        nxt.hr = pop_data.seq;
                        nxt.rw = '0;
                        flag   = 1'b1;
                    end
                    else if (pop_data.seq == cur.hr)
                    begin
                        flag = 1'b0;
                    end
                    else if (pop_data.seq > cur.hr)
                    begin
                        nxt.hr = pop_data.seq;
                        nxt.rw = (d_r <= WIN_SIZE) ? (w64[SEQ_W-1:0] & WIN_MASK) : '0;
                        flag   = 1'b1;
                    end
                    else if (d_r > WIN_SIZE)
                    begin
                        flag = 1'b0;
                    end
                    else if ((cur.rw & bit_r) != '0)
                    begin
                        flag = 1'b0;
                    end
                    else
                    begin
                        nxt.rw = cur.rw | bit_r;
                        flag   = 1'b1;
                    end
                end
                OP_ACK:
                begin
                    if (!(pop_data.ack == cur.pa && pop_data.bits == cur.pw) &&
                        (pop_data.ack > cur.pa ||
                         (cur.pa == '0 && pop_data.ack == '0 && pop_data.bits != '0)))
                    begin
                        nxt.pa = pop_data.ack;
                        nxt.pw = pop_data.bits;
                    end
                end
                OP_QUERY:
                begin
                    priority if (pop_data.seq == '0)
                    begin
                        flag = 1'b0;
                    end
                    else if (pop_data.seq == cur.pa)
                    begin
                        flag = 1'b1;
                    end
                    else if (cur.pa == '0 || pop_data.seq > cur.pa || d_q > WIN_SIZE)
                    begin
                        flag = 1'b0;
                    end
                    else
                    begin
                        flag = cur.pw[d_q_m1];
                    end
                end
                OP_CLEAR:
                begin
                    nxt = CHAN_RESET;
                end
                default:
                begin
                    nxt = cur;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                tbl_reg[i] <= CHAN_RESET;
            end
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop && pop_data.ch_ok)
            begin
                tbl_reg[pop_data.ch] <= nxt;
            end
            if (pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            flag_reg       <= flag;
            send_seq_reg   <= sent;
            local_ack_reg  <= pop_data.ch_ok ? nxt.hr : '0;
            local_bits_reg <= pop_data.ch_ok ? nxt.rw : '0;
            ch_ok_reg      <= pop_data.ch_ok;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.flag           = flag_reg;
    assign rsp.send_seq       = send_seq_reg;
    assign rsp.local_ack      = local_ack_reg;
    assign rsp.local_ack_bits = local_bits_reg;
    assign rsp.channel_ok     = ch_ok_reg;

endmodule

[rtl/core/per_channel_ack_window_tracker.sv]
// An accepted transaction is written into the queue, then executed by a read-modify-write of
// the per-channel table in the back end and held in the result register until taken.
// Throughput: one transaction per cycle while rsp.ready is high; a two-entry queue separates
// decode from execution. Reset: rst_n asynchronous, active low; every channel returns to next
// send 1 and all other state zero, the queue and the result register empty.
module per_channel_ack_window_tracker
    import awt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    awt_req_if.sink   req,
    awt_rsp_if.source rsp
);

    logic  push_valid, push_ready;
    work_t push_data;
    logic  pop_valid, pop_ready;
    work_t pop_data;

    awt_front u_front (
        .req        (req),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    awt_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    awt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .rsp       (rsp)
    );

endmodule

[rtl/core/awt_checker.sv]
module awt_checker
    import awt_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             out_valid,
    input logic             out_ready,
    input logic             flag,
    input logic [SEQ_W-1:0] send_seq,
    input logic [SEQ_W-1:0] local_ack,
    input logic [SEQ_W-1:0] local_ack_bits,
    input logic             channel_ok
);

    a_no_result_in_reset: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("result valid during reset");

    a_bad_channel_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !channel_ok) |->
            (!flag && send_seq == '0 && local_ack == '0 && local_ack_bits == '0))
        else $error("rejected channel reports nonzero fields");

    a_valid_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result dropped while stalled");

    a_payload_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            ($stable(flag) && $stable(send_seq) && $stable(local_ack) &&
             $stable(local_ack_bits) && $stable(channel_ok)))
        else $error("result changed while stalled");

endmodule

bind per_channel_ack_window_tracker awt_checker u_awt_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (rsp.valid),
    .out_ready      (rsp.ready),
    .flag           (rsp.flag),
    .send_seq       (rsp.send_seq),
    .local_ack      (rsp.local_ack),
    .local_ack_bits (rsp.local_ack_bits),
    .channel_ok     (rsp.channel_ok)
);
